>>> hw/rtl/sbsm_pkg.sv
package sbsm_pkg;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  data;
  } sbsm_req_t;

  typedef struct packed {
    logic [3:0] prg_bank_low;
    logic [3:0] prg_bank_high;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic       mirroring;
    logic       register_loaded;
  } sbsm_rsp_t;

  typedef enum logic [1:0] {
    SelCtrl = 2'd0,
    SelChrA = 2'd1,
    SelChrB = 2'd2,
    SelPrg  = 2'd3
  } sbsm_sel_e;

  localparam logic [4:0] CtrlReset     = 5'h0C;
  localparam logic [4:0] CtrlForce     = 5'h0C;
  localparam logic [3:0] PrgLastBank   = 4'hF;
  localparam logic [2:0] LoadLastCount = 3'd4;
  localparam logic [1:0] MirCodeVert   = 2'b10;
  localparam logic [1:0] MirCodeHorz   = 2'b11;

endpackage

>>> hw/rtl/serial_bank_switch_mapper_top.sv
// Serial bank-switch mapper: accepts one processor write request per clock while
// in_ready_o is high and returns, in the cycle after acceptance, the program banks,
// pattern banks and mirroring that hold after that write. The loader, bank registers
// and mapping logic update in a single registered pass, so the sustained rate is one
// request per cycle while results are taken; an output register decouples the result
// side; the input stays ready while a held result is taken. cfg_we_i loads mirroring.
module serial_bank_switch_mapper_top
  import sbsm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sbsm_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sbsm_rsp_t out_rsp_o
);

  logic [4:0] shift_q, shift_d;
  logic [2:0] count_q, count_d;
  logic [4:0] ctrl_q, ctrl_d;
  logic [4:0] chr_a_q, chr_a_d;
  logic [4:0] chr_b_q, chr_b_d;
  logic [4:0] prg_q, prg_d;
  logic       mirror_q, mirror_d;
  logic       out_valid_q;
  sbsm_rsp_t  rsp_q, rsp_d;

  logic       in_fire;
  logic       loaded;
  logic       remap;
  logic [3:0] prg_sel;
  sbsm_sel_e  sel;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
  assign sel         = sbsm_sel_e'(in_req_i.address[14:13]);

  always_comb begin
    shift_d = shift_q;
    count_d = count_q;
    ctrl_d  = ctrl_q;
    chr_a_d = chr_a_q;
    chr_b_d = chr_b_q;
    prg_d   = prg_q;
    loaded  = 1'b0;
    remap   = 1'b0;
    if (in_req_i.address[15]) begin
      if (in_req_i.data[7]) begin
        shift_d = '0;
        count_d = '0;
        ctrl_d  = ctrl_q | CtrlForce;
        remap   = 1'b1;
      end else if (count_q == LoadLastCount) begin
        shift_d = '0;
        count_d = '0;
        loaded  = 1'b1;
        remap   = 1'b1;
        unique case (sel)
          SelCtrl: ctrl_d  = {in_req_i.data[0], shift_q[4:1]};
          SelChrA: chr_a_d = {in_req_i.data[0], shift_q[4:1]};
          SelChrB: chr_b_d = {in_req_i.data[0], shift_q[4:1]};
          SelPrg:  prg_d   = {in_req_i.data[0], shift_q[4:1]};
          default: prg_d   = prg_q;
        endcase
      end else begin
        shift_d = {in_req_i.data[0], shift_q[4:1]};
        count_d = count_q + 3'd1;
      end
    end
  end

  always_comb begin
    mirror_d = mirror_q;
    if (remap) begin
      if (ctrl_d[1:0] == MirCodeVert) begin
        mirror_d = 1'b0;
      end else if (ctrl_d[1:0] == MirCodeHorz) begin
        mirror_d = 1'b1;
      end
    end
  end

  always_comb begin
    prg_sel = prg_d[3:0];
    if (ctrl_d[3]) begin
      if (ctrl_d[2]) begin
        rsp_d.prg_bank_low  = prg_sel;
        rsp_d.prg_bank_high = PrgLastBank;
      end else begin
        rsp_d.prg_bank_low  = '0;
        rsp_d.prg_bank_high = prg_sel;
      end
    end else begin
      rsp_d.prg_bank_low  = {prg_sel[3:1], 1'b0};
      rsp_d.prg_bank_high = {prg_sel[3:1], 1'b1};
    end
    if (ctrl_d[4]) begin
      rsp_d.chr_bank_low  = chr_a_d;
      rsp_d.chr_bank_high = chr_b_d;
    end else begin
      rsp_d.chr_bank_low  = {chr_a_d[4:1], 1'b0};
      rsp_d.chr_bank_high = {chr_a_d[4:1], 1'b1};
    end
    rsp_d.mirroring       = mirror_d;
    rsp_d.register_loaded = loaded;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      count_q     <= '0;
      ctrl_q      <= CtrlReset;
      chr_a_q     <= '0;
      chr_b_q     <= '0;
      prg_q       <= '0;
      mirror_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mirror_q <= cfg_wdata_i;
      end else if (in_fire) begin
        mirror_q <= mirror_d;
      end
      if (in_fire) begin
        shift_q     <= shift_d;
        count_q     <= count_d;
        ctrl_q      <= ctrl_d;
        chr_a_q     <= chr_a_d;
        chr_b_q     <= chr_b_d;
        prg_q       <= prg_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rsp_q <= rsp_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LoadLastCount)
    else $error("loader count out of range");

  a_loaded_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rsp_q.register_loaded |-> count_q == 3'd0 && shift_q == 5'd0)
    else $error("loader not cleared after load");

  a_reset_forces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_req_i.address[15] && in_req_i.data[7] |=> ctrl_q[3:2] == 2'b11)
    else $error("loader reset did not force bank mode");

  a_low_addr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_req_i.address[15] |=>
      $stable(ctrl_q) && $stable(prg_q) && $stable(count_q) && $stable(chr_a_q))
    else $error("low address write changed state");

  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted request produced no result");

endmodule

>>> test/serial_bank_switch_mapper_top_test.sv
`timescale 1ns / 100ps

module serial_bank_switch_mapper_top_test
  import sbsm_pkg::*;
();

  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 300;

  class bank_map_board;
    logic [4:0] shreg = '0;
    logic [2:0] nbits = '0;
    logic [4:0] ctrl  = CtrlReset;
    logic [4:0] chr_a = '0;
    logic [4:0] chr_b = '0;
    logic [4:0] prg   = '0;
    logic       mir   = 1'b0;
    sbsm_rsp_t  expected_maps[$];
    int         errors = 0;

    function void load_header(logic v);
      mir = v;
    endfunction

    function void follow_mirroring();
      if (ctrl[1:0] == MirCodeVert) begin
        mir = 1'b0;
      end else if (ctrl[1:0] == MirCodeHorz) begin
        mir = 1'b1;
      end
    endfunction

    function void note_write(sbsm_req_t r);
      sbsm_rsp_t  m;
      logic [3:0] p;
      m = '0;
      if (r.address[15]) begin
        if (r.data[7]) begin
          shreg = '0;
          nbits = '0;
          ctrl  = ctrl | CtrlForce;
          follow_mirroring();
        end else begin
          shreg = {r.data[0], shreg[4:1]};
          if (nbits == LoadLastCount) begin
            case (sbsm_sel_e'(r.address[14:13]))
              SelCtrl: ctrl  = shreg;
              SelChrA: chr_a = shreg;
              SelChrB: chr_b = shreg;
              default: prg   = shreg;
            endcase
            shreg = '0;
            nbits = '0;
            m.register_loaded = 1'b1;
            follow_mirroring();
          end else begin
            nbits = nbits + 3'd1;
          end
        end
      end
      p = prg[3:0];
      if (ctrl[3]) begin
        if (ctrl[2]) begin
          m.prg_bank_low  = p;
          m.prg_bank_high = PrgLastBank;
        end else begin
          m.prg_bank_low  = 4'h0;
          m.prg_bank_high = p;
        end
      end else begin
        m.prg_bank_low  = {p[3:1], 1'b0};
        m.prg_bank_high = {p[3:1], 1'b1};
      end
      if (ctrl[4]) begin
        m.chr_bank_low  = chr_a;
        m.chr_bank_high = chr_b;
      end else begin
        m.chr_bank_low  = {chr_a[4:1], 1'b0};
        m.chr_bank_high = {chr_a[4:1], 1'b1};
      end
      m.mirroring = mir;
      expected_maps.push_back(m);
    endfunction

    function void check_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
        $error("%s expected %0d actual %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_map(sbsm_rsp_t got);
      sbsm_rsp_t e;
      if (expected_maps.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = expected_maps.pop_front();
      check_field("prg_bank_low", e.prg_bank_low, got.prg_bank_low);
      check_field("prg_bank_high", e.prg_bank_high, got.prg_bank_high);
      check_field("chr_bank_low", e.chr_bank_low, got.chr_bank_low);
      check_field("chr_bank_high", e.chr_bank_high, got.chr_bank_high);
      check_field("mirroring", e.mirroring, got.mirroring);
      check_field("register_loaded", e.register_loaded, got.register_loaded);
    endfunction

    function int pending();
      return expected_maps.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic      cfg_wdata_i;
  logic      in_valid_i;
  logic      in_ready_o;
  sbsm_req_t in_req_i;
  logic      out_valid_o;
  logic      out_ready_i;
  sbsm_rsp_t out_rsp_o;

  bank_map_board board;
  bit steady_tx;
  bit steady_rx;
  bit hold_off;
  int cycle_count;
  int high_writes;

  serial_bank_switch_mapper_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        board.load_header(cfg_wdata_i);
      end
      if (in_valid_i && in_ready_o) begin
        board.note_write(in_req_i);
      end
      if (out_valid_o && out_ready_i) begin
        board.check_map(out_rsp_o);
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (steady_rx) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  task automatic put_write(input logic [15:0] a, input logic [7:0] d);
    int n;
    in_valid_i       <= 1'b1;
    in_req_i.address <= a;
    in_req_i.data    <= d;
    do @(posedge clk_i); while (!in_ready_o);
    if (a[15]) high_writes++;
    n = steady_tx ? 0 : gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic shift_in(input sbsm_sel_e sel, input logic [4:0] v, input int nbit,
                          input bit noise);
    logic [15:0] a;
    logic [7:0]  d;
    for (int i = 0; i < nbit; i++) begin
      a = 16'($urandom_range(16'h8000, 16'hFFFF));
      if (i == 4) a[14:13] = sel;
      d = 8'($urandom);
      d[7] = 1'b0;
      d[0] = v[i];
      put_write(a, d);
      if (noise && $urandom_range(0, 9) == 0) begin
        put_write(16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
      end
    end
  endtask

  task automatic loader_reset();
    put_write(16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom) | 8'h80);
  endtask

  task automatic run_random(input int count);
    int target;
    int r;
    target = high_writes + count;
    while (high_writes < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        shift_in(sbsm_sel_e'($urandom_range(0, 3)), 5'($urandom), 5, 1'b1);
      end else if (r < 80) begin
        loader_reset();
      end else if (r < 90) begin
        put_write(16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
      end else begin
        shift_in(sbsm_sel_e'($urandom_range(0, 3)), 5'($urandom), $urandom_range(1, 4),
                 1'b0);
        loader_reset();
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_header(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    board       = new;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    steady_tx   = 1'b0;
    steady_rx   = 1'b0;
    hold_off    = 1'b0;
    cycle_count = 0;
    high_writes = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_header(1'b1);
    put_write(16'h8000, 8'h80);
    put_write(16'h0000, 8'h00);
    put_write(16'h7FFF, 8'hFF);
    shift_in(SelCtrl, 5'h1F, 5, 1'b0);
    put_write(16'h7FFF, 8'h01);
    shift_in(SelPrg, 5'h1F, 5, 1'b0);
    shift_in(SelChrA, 5'h15, 5, 1'b0);
    shift_in(SelChrB, 5'h0A, 5, 1'b0);
    put_write(16'hFFFF, 8'hFF);
    drain();

    set_header(1'b0);
    run_random(300);
    drain();

    set_header(1'b1);
    steady_tx = 1'b1;
    steady_rx = 1'b1;
    run_random(200);
    drain();

    steady_rx = 1'b0;
    hold_off  = 1'b1;
    run_random(60);
    steady_tx = 1'b0;
    drain();

    set_header(1'b0);
    run_random(250);
    drain();
    repeat (10) @(posedge clk_i);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
